FILE: rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared widths and codes for the transaction label table.
// ----------------------------------------------------------------------------
package tlt_pkg;

  localparam int ACT_W  = 2;
  localparam int NODE_W = 16;
  localparam int LBL_W  = 6;
  localparam int CODE_W = 4;
  localparam int STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd3;

  localparam logic [STAT_W-1:0] ST_ALLOCATED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY        = 3'd1;
  localparam logic [STAT_W-1:0] ST_MATCHED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNEXPECTED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FINISHED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_PENDING = 3'd5;
  localparam logic [STAT_W-1:0] ST_FLUSHED     = 3'd6;
  localparam logic [STAT_W-1:0] ST_FLUSH_EMPTY = 3'd7;

endpackage

FILE: rtl/tlt_req_if.sv
// ----------------------------------------------------------------------------
// tlt_req_if
// Request channel: one transfer carries one label table action.
// ----------------------------------------------------------------------------
interface tlt_req_if;
  import tlt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NODE_W-1:0] target_node;
  logic [LBL_W-1:0]  label_in;
  logic [NODE_W-1:0] source_node;
  logic [CODE_W-1:0] code_in;

  modport source (output valid, action, target_node, label_in, source_node, code_in,
                  input ready);
  modport sink   (input valid, action, target_node, label_in, source_node, code_in,
                  output ready);
endinterface

FILE: rtl/tlt_rsp_if.sv
// ----------------------------------------------------------------------------
// tlt_rsp_if
// Result channel: one transfer carries one label table result.
// ----------------------------------------------------------------------------
interface tlt_rsp_if;
  import tlt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LBL_W-1:0]  label_out;
  logic [NODE_W-1:0] node_out;
  logic [CODE_W-1:0] code_out;
  logic              last;

  modport source (output valid, status, label_out, node_out, code_out, last,
                  input ready);
  modport sink   (input valid, status, label_out, node_out, code_out, last,
                  output ready);
endinterface

FILE: rtl/transaction_label_table_unit.sv
// ----------------------------------------------------------------------------
// Results: an empty flush, an allocate with all labels busy, or a response or
// finish to a label not pending is answered from the request itself; other
// responses and finishes first read the node store; allocate first skips the
// busy labels after the last issued one. Flush reports each pending label in
// ascending order with its node, the final one marked last. Throughput: one
// action at a time, the next taken as its last result transfers. Reset: busy
// map clears, last issued label set to LABEL_COUNT-1; node store not cleared.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// transaction_label_table_unit
// Split-transaction label allocator with a sequenced scan unit.
// ----------------------------------------------------------------------------
module transaction_label_table_unit #(
  parameter int LABEL_COUNT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlt_req_if.sink   in_i,
  tlt_rsp_if.source out_o
);
  import tlt_pkg::*;

  localparam int LW = $clog2(LABEL_COUNT);
  localparam logic [LW-1:0]    LastLabel  = LW'(LABEL_COUNT - 1);
  localparam logic [LBL_W:0]   LabelLimit = (LBL_W + 1)'(LABEL_COUNT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_FDATA = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [LABEL_COUNT-1:0] busy_q, busy_d, busy_clr;
  logic [LW-1:0]          last_q, last_d;
  logic [LW-1:0]          idx_q, idx_d;
  logic [ACT_W-1:0]       act_q;
  logic [NODE_W-1:0]      target_q;
  logic [NODE_W-1:0]      src_q;
  logic [CODE_W-1:0]      code_q;

  logic                   out_valid_q;
  logic [STAT_W-1:0]      out_status_q;
  logic [LBL_W-1:0]       out_label_q;
  logic [NODE_W-1:0]      out_node_q;
  logic [CODE_W-1:0]      out_code_q;
  logic                   out_last_q;

  logic                   emit;
  logic [STAT_W-1:0]      res_status;
  logic [LBL_W-1:0]       res_label;
  logic [NODE_W-1:0]      res_node;
  logic [CODE_W-1:0]      res_code;
  logic                   res_last;

  logic                   out_free, in_fire;
  logic [LW-1:0]          step_cur, step_next;
  logic                   step_hit;
  logic                   lab_ok, in_pend;
  logic [LW-1:0]          lab_idx;

  logic                   we, re;
  logic [LW-1:0]          raddr;
  logic [NODE_W-1:0]      rdata;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign step_cur = (state_q == S_IDLE) ? last_q : idx_q;

  tlt_step #(
    .LABEL_COUNT (LABEL_COUNT),
    .LW          (LW)
  ) u_step (
    .cur_i  (step_cur),
    .busy_i (busy_q),
    .next_o (step_next),
    .hit_o  (step_hit)
  );

  tlt_node_ram #(
    .DEPTH (LABEL_COUNT),
    .AW    (LW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (target_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign lab_ok   = {1'b0, in_i.label_in} < LabelLimit;
  assign lab_idx  = in_i.label_in[LW-1:0];
  assign in_pend  = lab_ok && busy_q[lab_idx];
  assign busy_clr = busy_q & ~({{(LABEL_COUNT-1){1'b0}}, 1'b1} << idx_q);

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    last_d     = last_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    res_status = ST_ALLOCATED;
    res_label  = '0;
    res_node   = '0;
    res_code   = '0;
    res_last   = 1'b1;
    we         = 1'b0;
    re         = 1'b0;
    raddr      = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.action)
            ACT_ALLOC: begin
              if (&busy_q) begin
                emit       = 1'b1;
                res_status = ST_BUSY;
              end else begin
                idx_d   = step_next;
                state_d = S_SCAN;
              end
            end
            ACT_RESP, ACT_FINISH: begin
              if (!in_pend) begin
                emit       = 1'b1;
                res_status = (in_i.action == ACT_RESP) ? ST_UNEXPECTED : ST_NOT_PENDING;
                res_label  = in_i.label_in;
              end else begin
                re      = 1'b1;
                raddr   = lab_idx;
                idx_d   = lab_idx;
                state_d = S_RDATA;
              end
            end
            default: begin
              last_d = LastLabel;
              if (busy_q == '0) begin
                emit       = 1'b1;
                res_status = ST_FLUSH_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_FSCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!step_hit) begin
          if (out_free) begin
            emit          = 1'b1;
            res_status    = ST_ALLOCATED;
            res_label     = LBL_W'(idx_q);
            res_node      = target_q;
            busy_d[idx_q] = 1'b1;
            we            = 1'b1;
            last_d        = idx_q;
            state_d       = S_IDLE;
          end
        end else begin
          idx_d = step_next;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          emit      = 1'b1;
          res_label = LBL_W'(idx_q);
          res_node  = rdata;
          state_d   = S_IDLE;
          if (act_q == ACT_RESP) begin
            if (rdata == src_q) begin
              res_status = ST_MATCHED;
              res_code   = code_q;
              busy_d     = busy_clr;
            end else begin
              res_status = ST_UNEXPECTED;
            end
          end else begin
            res_status = ST_FINISHED;
            res_code   = code_q;
            busy_d     = busy_clr;
          end
        end
      end
      S_FSCAN: begin
        if (step_hit) begin
          re      = 1'b1;
          state_d = S_FDATA;
        end else begin
          idx_d = step_next;
        end
      end
      S_FDATA: begin
        if (out_free) begin
          emit       = 1'b1;
          res_status = ST_FLUSHED;
          res_label  = LBL_W'(idx_q);
          res_node   = rdata;
          res_last   = (busy_clr == '0);
          busy_d     = busy_clr;
          if (busy_clr == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = step_next;
            state_d = S_FSCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      last_q      <= LastLabel;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= in_i.action;
      target_q <= in_i.target_node;
      src_q    <= in_i.source_node;
      code_q   <= in_i.code_in;
    end
    if (emit) begin
      out_status_q <= res_status;
      out_label_q  <= res_label;
      out_node_q   <= res_node;
      out_code_q   <= res_code;
      out_last_q   <= res_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.label_out = out_label_q;
  assign out_o.node_out  = out_node_q;
  assign out_o.code_out  = out_code_q;
  assign out_o.last      = out_last_q;
endmodule

FILE: rtl/tlt_node_ram.sv
// ----------------------------------------------------------------------------
// tlt_node_ram
// Destination node store, one entry per label; registered read port.
// ----------------------------------------------------------------------------
module tlt_node_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tlt_pkg::NODE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tlt_pkg::NODE_W-1:0] rdata_o
);
  import tlt_pkg::*;

  logic [NODE_W-1:0] mem_q [DEPTH];
  logic [NODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/tlt_step.sv
// ----------------------------------------------------------------------------
// tlt_step
// Shared scan step: busy test of the current label and round-robin successor.
// ----------------------------------------------------------------------------
module tlt_step #(
  parameter int LABEL_COUNT = 64,
  parameter int LW          = 6
) (
  input  logic [LW-1:0]          cur_i,
  input  logic [LABEL_COUNT-1:0] busy_i,
  output logic [LW-1:0]          next_o,
  output logic                   hit_o
);
  localparam logic [LW-1:0] LastLabel = LW'(LABEL_COUNT - 1);

  assign next_o = (cur_i >= LastLabel) ? '0 : cur_i + LW'(1);
  assign hit_o  = busy_i[cur_i];
endmodule

FILE: sim/tlt_label_checker.sv
// ----------------------------------------------------------------------------
// tlt_label_checker
// Watches the request and result channels of the transaction label table.
// Keeps its own busy map, last issued label and node store, works out the
// results of every accepted request and compares each accepted result field
// by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module tlt_label_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tlt_req_if   req_i,
  tlt_rsp_if   rsp_i,
  output int   mismatch_cnt_o,
  output int   outstanding_o
);
  import tlt_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LBL_W-1:0]  lbl;
    logic [NODE_W-1:0] node;
    logic [CODE_W-1:0] code;
    logic              fin;
  } outcome_t;

  outcome_t          outcome_q[$];
  logic [63:0]       busy_map;
  logic [LBL_W-1:0]  last_label;
  logic [NODE_W-1:0] node_mem [64];
  int                err_cnt;

  function automatic outcome_t make_outcome(logic [STAT_W-1:0] status, logic [LBL_W-1:0] lbl,
                                            logic [NODE_W-1:0] node, logic [CODE_W-1:0] code,
                                            logic fin);
    outcome_t o;
    o.status = status;
    o.lbl    = lbl;
    o.node   = node;
    o.code   = code;
    o.fin    = fin;
    return o;
  endfunction

  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] target,
                              input logic [LBL_W-1:0] lbl, input logic [NODE_W-1:0] src,
                              input logic [CODE_W-1:0] code);
    logic [LBL_W-1:0] idx;
    outcome_t         prev;
    bit               have_prev;
    have_prev = 1'b0;
    case (act)
      ACT_ALLOC: begin
        if (&busy_map) begin
          outcome_q.push_back(make_outcome(ST_BUSY, '0, '0, '0, 1'b1));
        end else begin
          idx = last_label + 1'b1;
          while (busy_map[idx]) idx = idx + 1'b1;
          last_label    = idx;
          busy_map[idx] = 1'b1;
          node_mem[idx] = target;
          outcome_q.push_back(make_outcome(ST_ALLOCATED, idx, target, '0, 1'b1));
        end
      end
      ACT_RESP: begin
        if (!busy_map[lbl]) begin
          outcome_q.push_back(make_outcome(ST_UNEXPECTED, lbl, '0, '0, 1'b1));
        end else if (node_mem[lbl] != src) begin
          outcome_q.push_back(make_outcome(ST_UNEXPECTED, lbl, node_mem[lbl], '0, 1'b1));
        end else begin
          busy_map[lbl] = 1'b0;
          outcome_q.push_back(make_outcome(ST_MATCHED, lbl, node_mem[lbl], code, 1'b1));
        end
      end
      ACT_FINISH: begin
        if (!busy_map[lbl]) begin
          outcome_q.push_back(make_outcome(ST_NOT_PENDING, lbl, '0, '0, 1'b1));
        end else begin
          busy_map[lbl] = 1'b0;
          outcome_q.push_back(make_outcome(ST_FINISHED, lbl, node_mem[lbl], code, 1'b1));
        end
      end
      default: begin
        // cancelled labels in ascending order, final one flagged
        for (int i = 0; i < 64; i++) begin
          if (busy_map[i]) begin
            if (have_prev) outcome_q.push_back(prev);
            prev      = make_outcome(ST_FLUSHED, LBL_W'(i), node_mem[i], '0, 1'b0);
            have_prev = 1'b1;
          end
        end
        if (have_prev) begin
          prev.fin = 1'b1;
          outcome_q.push_back(prev);
        end else begin
          outcome_q.push_back(make_outcome(ST_FLUSH_EMPTY, '0, '0, '0, 1'b1));
        end
        busy_map   = '0;
        last_label = '1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      busy_map   = '0;
      last_label = '1;
      err_cnt    = 0;
      outcome_q.delete();
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.status, rsp_i.label_out, rsp_i.node_out, rsp_i.code_out, rsp_i.last};
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result with none expected: st=%0d lbl=%0d node=%h code=%h last=%b",
                     got.status, got.lbl, got.node, got.code, got.fin);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result differs: exp st=%0d lbl=%0d node=%h code=%h last=%b",
                       want.status, want.lbl, want.node, want.code, want.fin);
              $display("                got st=%0d lbl=%0d node=%h code=%h last=%b",
                       got.status, got.lbl, got.node, got.code, got.fin);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready)
        apply_action(req_i.action, req_i.target_node, req_i.label_in, req_i.source_node,
                     req_i.code_in);
      mismatch_cnt_o <= err_cnt;
      outstanding_o  <= outcome_q.size();
    end
  end

endmodule

FILE: sim/tb_transaction_label_table_unit.sv
// ----------------------------------------------------------------------------
// tb_transaction_label_table_unit
// Drives the transaction label table with a directed set of actions and then
// random traffic whose responses and finishes mostly aim at labels seen to be
// pending, with table fills and flushes. Both sides idle at random; the result
// side holds off once for a long stretch. The checker reports mismatches.
// ----------------------------------------------------------------------------
module tb_transaction_label_table_unit;
  import tlt_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_cnt;
  int   outstanding;
  int   burst_left;
  int   idle_cycles;

  bit   [63:0]       live_map;
  logic [NODE_W-1:0] live_node [64];

  tlt_req_if in_if ();
  tlt_rsp_if out_if ();

  transaction_label_table_unit #(.LABEL_COUNT(64)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tlt_label_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (in_if),
    .rsp_i          (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // labels seen pending on the result side, used to aim responses and finishes
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      case (out_if.status)
        ST_ALLOCATED: begin
          live_map[out_if.label_out]  <= 1'b1;
          live_node[out_if.label_out] <= out_if.node_out;
        end
        ST_MATCHED, ST_FINISHED, ST_FLUSHED: live_map[out_if.label_out] <= 1'b0;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_action(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] target,
                             input logic [LBL_W-1:0] lbl, input logic [NODE_W-1:0] src,
                             input logic [CODE_W-1:0] code);
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.target_node <= target;
    in_if.label_in    <= lbl;
    in_if.source_node <= src;
    in_if.code_in     <= code;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  function automatic int pick_live();
    int cand[$];
    for (int i = 0; i < 64; i++)
      if (live_map[i]) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic send_random();
    int                r;
    int                lbl;
    logic [NODE_W-1:0] src;
    r   = $urandom_range(0, 99);
    lbl = pick_live();
    if (r < 40) begin
      send_action(ACT_ALLOC, NODE_W'($urandom), LBL_W'($urandom), NODE_W'($urandom),
                  CODE_W'($urandom));
    end else if (r < 70) begin
      if (lbl < 0 || $urandom_range(0, 9) == 0) begin
        send_action(ACT_RESP, NODE_W'($urandom), LBL_W'($urandom), NODE_W'($urandom),
                    CODE_W'($urandom));
      end else begin
        src = live_node[lbl];
        if ($urandom_range(0, 5) == 0) src = src ^ NODE_W'(1 << $urandom_range(0, 15));
        send_action(ACT_RESP, NODE_W'($urandom), LBL_W'(lbl), src, CODE_W'($urandom));
      end
    end else if (r < 94) begin
      if (lbl < 0 || $urandom_range(0, 7) == 0)
        send_action(ACT_FINISH, NODE_W'($urandom), LBL_W'($urandom), NODE_W'($urandom),
                    CODE_W'($urandom));
      else
        send_action(ACT_FINISH, NODE_W'($urandom), LBL_W'(lbl), NODE_W'($urandom),
                    CODE_W'($urandom));
    end else begin
      send_action(ACT_FLUSH, NODE_W'($urandom), LBL_W'($urandom), NODE_W'($urandom),
                  CODE_W'($urandom));
    end
  endtask

  initial begin : rx_pattern
    int cyc;
    int span;
    int mode;
    bit held;
    cyc  = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) begin
          @(posedge clk_i);
          cyc++;
        end
      end else begin
        mode = $urandom_range(0, 9);
        span = (mode == 9) ? $urandom_range(1, 25) : $urandom_range(10, 60);
        repeat (span) begin
          if (mode < 4)
            out_if.ready <= 1'b1;
          else if (mode < 9)
            out_if.ready <= ($urandom_range(0, 99) < 60);
          else
            out_if.ready <= 1'b0;
          @(posedge clk_i);
          cyc++;
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    bit filled;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_ALLOC;
    in_if.target_node <= '0;
    in_if.label_in    <= '0;
    in_if.source_node <= '0;
    in_if.code_in     <= '0;
    burst_left = 4;
    sent       = 0;
    filled     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_action(ACT_FLUSH,  16'h0000, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_FINISH, 16'h0000, 6'd0,  16'h0000, 4'hF);
    send_action(ACT_RESP,   16'hFFFF, 6'd63, 16'hFFFF, 4'hF);
    send_action(ACT_ALLOC,  16'h0000, 6'd63, 16'hFFFF, 4'hF);
    send_action(ACT_ALLOC,  16'hFFFF, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_ALLOC,  16'h5A5A, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_RESP,   16'h0000, 6'd1,  16'h0000, 4'h3);
    send_action(ACT_RESP,   16'h0000, 6'd1,  16'hFFFF, 4'hF);
    send_action(ACT_FINISH, 16'h0000, 6'd0,  16'h0000, 4'hF);
    send_action(ACT_FINISH, 16'h0000, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_ALLOC,  16'h1234, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_ALLOC,  16'hA5A5, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_RESP,   16'h0000, 6'd2,  16'h5A5A, 4'h0);
    send_action(ACT_FLUSH,  16'hFFFF, 6'd63, 16'hFFFF, 4'hF);
    send_action(ACT_ALLOC,  16'h8001, 6'd0,  16'h0000, 4'h0);
    send_action(ACT_FINISH, 16'h0000, 6'd0,  16'h0000, 4'h5);
    send_action(ACT_RESP,   16'h0000, 6'd63, 16'h0000, 4'h0);
    send_action(ACT_FLUSH,  16'h0000, 6'd0,  16'h0000, 4'h0);

    while (sent < RANDOM_ITEMS) begin
      if ((!filled && sent >= 120) || $urandom_range(0, 99) < 2) begin
        // fill the table and run past it into the busy case
        filled = 1'b1;
        repeat (64 + $urandom_range(1, 3)) begin
          send_action(ACT_ALLOC, NODE_W'($urandom), LBL_W'($urandom), NODE_W'($urandom),
                      CODE_W'($urandom));
          sent++;
        end
      end else begin
        send_random();
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/tlt_pkg.sv
rtl/tlt_req_if.sv
rtl/tlt_rsp_if.sv
rtl/tlt_node_ram.sv
rtl/tlt_step.sv
rtl/transaction_label_table_unit.sv
sim/tlt_label_checker.sv
sim/tb_transaction_label_table_unit.sv
